FILE: design/imuof_pkg.sv
// Shared types, constants and the sequencer program of the IMU orientation filter.
`default_nettype none
package imuof_pkg;

    localparam int RF_WIDTH = 64;
    localparam int RF_DEPTH = 16;
    localparam int RF_AW    = $clog2(RF_DEPTH);

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    localparam logic CFG_BETA = 1'b0;
    localparam logic CFG_STEP = 1'b1;

    typedef enum logic [1:0] {
        OP_MAC,
        OP_NORM,
        OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FETCH,
        ST_OPER,
        ST_MULT,
        ST_ACCUM,
        ST_NS_RD,
        ST_NS_CHK,
        ST_N_SHIFT,
        ST_NQ_RD,
        ST_NQ_OP,
        ST_NQ_MUL,
        ST_NQ_ACC,
        ST_N_SQRT,
        ST_ND_RD,
        ST_ND_OP,
        ST_N_DIV,
        ST_N_WR,
        ST_OUT
    } state_t;

    typedef logic [4:0] addr_t;

    // Scratch file addresses; the quaternion squares and the integrated
    // quaternion share the same entries.
    localparam addr_t A_QQ0  = 5'd0;
    localparam addr_t A_QQ1  = 5'd1;
    localparam addr_t A_QQ2  = 5'd2;
    localparam addr_t A_QQ3  = 5'd3;
    localparam addr_t A_NQ0  = 5'd0;
    localparam addr_t A_NQ1  = 5'd1;
    localparam addr_t A_NQ2  = 5'd2;
    localparam addr_t A_NQ3  = 5'd3;
    localparam addr_t A_S0   = 5'd4;
    localparam addr_t A_S1   = 5'd5;
    localparam addr_t A_S2   = 5'd6;
    localparam addr_t A_S3   = 5'd7;
    localparam addr_t A_QD0  = 5'd8;
    localparam addr_t A_QD1  = 5'd9;
    localparam addr_t A_QD2  = 5'd10;
    localparam addr_t A_QD3  = 5'd11;
    localparam addr_t A_AN0  = 5'd12;
    localparam addr_t A_AN1  = 5'd13;
    localparam addr_t A_AN2  = 5'd14;
    // Register sources, all with the top address bit set.
    localparam addr_t A_Q0   = 5'd16;
    localparam addr_t A_Q1   = 5'd17;
    localparam addr_t A_Q2   = 5'd18;
    localparam addr_t A_Q3   = 5'd19;
    localparam addr_t A_GX   = 5'd20;
    localparam addr_t A_GY   = 5'd21;
    localparam addr_t A_GZ   = 5'd22;
    localparam addr_t A_AX   = 5'd23;
    localparam addr_t A_AY   = 5'd24;
    localparam addr_t A_AZ   = 5'd25;
    localparam addr_t A_BETA = 5'd26;
    localparam addr_t A_TS   = 5'd27;
    localparam addr_t A_ONE  = 5'd28;

    localparam logic POS = 1'b0;
    localparam logic NEG = 1'b1;
    localparam logic [1:0] X1 = 2'd0;
    localparam logic [1:0] X2 = 2'd1;
    localparam logic [1:0] X4 = 2'd2;
    localparam logic [1:0] X8 = 2'd3;

    localparam int PC_W = 6;

    typedef struct packed {
        op_t        op;
        logic       cond;
        addr_t      a;
        addr_t      b;
        addr_t      d;
        logic [5:0] sh;
        logic       hi;
        logic       cneg;
        logic [1:0] clog;
        logic       st;
        logic [2:0] cnt;
    } uop_t;

    function automatic uop_t mac(input logic cond, input addr_t a, input addr_t b,
                                 input logic [5:0] sh, input logic hi, input logic cneg,
                                 input logic [1:0] clog, input logic st, input addr_t d);
        uop_t u;
        u      = '0;
        u.op   = OP_MAC;
        u.cond = cond;
        u.a    = a;
        u.b    = b;
        u.d    = d;
        u.sh   = sh;
        u.hi   = hi;
        u.cneg = cneg;
        u.clog = clog;
        u.st   = st;
        return u;
    endfunction

    function automatic uop_t norm(input logic cond, input addr_t a, input addr_t d,
                                  input logic [2:0] cnt);
        uop_t u;
        u      = '0;
        u.op   = OP_NORM;
        u.cond = cond;
        u.a    = a;
        u.d    = d;
        u.cnt  = cnt;
        return u;
    endfunction

    function automatic uop_t fin();
        uop_t u;
        u    = '0;
        u.op = OP_OUT;
        return u;
    endfunction

    function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            6'd0:  u = norm(1'b1, A_AX, A_AN0, 3'd3);
            6'd1:  u = mac(1'b1, A_Q0, A_Q0, 6'd30, 1'b0, POS, X1, 1'b1, A_QQ0);
            6'd2:  u = mac(1'b1, A_Q1, A_Q1, 6'd30, 1'b0, POS, X1, 1'b1, A_QQ1);
            6'd3:  u = mac(1'b1, A_Q2, A_Q2, 6'd30, 1'b0, POS, X1, 1'b1, A_QQ2);
            6'd4:  u = mac(1'b1, A_Q3, A_Q3, 6'd30, 1'b0, POS, X1, 1'b1, A_QQ3);
            6'd5:  u = mac(1'b1, A_Q0, A_QQ2, 6'd30, 1'b0, POS, X4, 1'b0, A_S0);
            6'd6:  u = mac(1'b1, A_Q2, A_AN0, 6'd30, 1'b0, POS, X2, 1'b0, A_S0);
            6'd7:  u = mac(1'b1, A_Q0, A_QQ1, 6'd30, 1'b0, POS, X4, 1'b0, A_S0);
            6'd8:  u = mac(1'b1, A_Q1, A_AN1, 6'd30, 1'b0, NEG, X2, 1'b1, A_S0);
            6'd9:  u = mac(1'b1, A_Q1, A_QQ3, 6'd30, 1'b0, POS, X4, 1'b0, A_S1);
            6'd10: u = mac(1'b1, A_Q3, A_AN0, 6'd30, 1'b0, NEG, X2, 1'b0, A_S1);
            6'd11: u = mac(1'b1, A_Q1, A_QQ0, 6'd30, 1'b0, POS, X4, 1'b0, A_S1);
            6'd12: u = mac(1'b1, A_Q0, A_AN1, 6'd30, 1'b0, NEG, X2, 1'b0, A_S1);
            6'd13: u = mac(1'b1, A_Q1, A_ONE, 6'd0, 1'b0, NEG, X4, 1'b0, A_S1);
            6'd14: u = mac(1'b1, A_Q1, A_QQ1, 6'd30, 1'b0, POS, X8, 1'b0, A_S1);
            6'd15: u = mac(1'b1, A_Q1, A_QQ2, 6'd30, 1'b0, POS, X8, 1'b0, A_S1);
            6'd16: u = mac(1'b1, A_Q1, A_AN2, 6'd30, 1'b0, POS, X4, 1'b1, A_S1);
            6'd17: u = mac(1'b1, A_Q2, A_QQ0, 6'd30, 1'b0, POS, X4, 1'b0, A_S2);
            6'd18: u = mac(1'b1, A_Q0, A_AN0, 6'd30, 1'b0, POS, X2, 1'b0, A_S2);
            6'd19: u = mac(1'b1, A_Q2, A_QQ3, 6'd30, 1'b0, POS, X4, 1'b0, A_S2);
            6'd20: u = mac(1'b1, A_Q3, A_AN1, 6'd30, 1'b0, NEG, X2, 1'b0, A_S2);
            6'd21: u = mac(1'b1, A_Q2, A_ONE, 6'd0, 1'b0, NEG, X4, 1'b0, A_S2);
            6'd22: u = mac(1'b1, A_Q2, A_QQ1, 6'd30, 1'b0, POS, X8, 1'b0, A_S2);
            6'd23: u = mac(1'b1, A_Q2, A_QQ2, 6'd30, 1'b0, POS, X8, 1'b0, A_S2);
            6'd24: u = mac(1'b1, A_Q2, A_AN2, 6'd30, 1'b0, POS, X4, 1'b1, A_S2);
            6'd25: u = mac(1'b1, A_Q3, A_QQ1, 6'd30, 1'b0, POS, X4, 1'b0, A_S3);
            6'd26: u = mac(1'b1, A_Q1, A_AN0, 6'd30, 1'b0, NEG, X2, 1'b0, A_S3);
            6'd27: u = mac(1'b1, A_Q3, A_QQ2, 6'd30, 1'b0, POS, X4, 1'b0, A_S3);
            6'd28: u = mac(1'b1, A_Q2, A_AN1, 6'd30, 1'b0, NEG, X2, 1'b1, A_S3);
            6'd29: u = norm(1'b1, A_S0, A_S0, 3'd4);
            6'd30: u = mac(1'b1, A_S0, A_BETA, 6'd16, 1'b0, NEG, X1, 1'b0, A_QD0);
            6'd31: u = mac(1'b0, A_GX, A_Q1, 6'd17, 1'b0, NEG, X1, 1'b0, A_QD0);
            6'd32: u = mac(1'b0, A_GY, A_Q2, 6'd17, 1'b0, NEG, X1, 1'b0, A_QD0);
            6'd33: u = mac(1'b0, A_GZ, A_Q3, 6'd17, 1'b0, NEG, X1, 1'b1, A_QD0);
            6'd34: u = mac(1'b1, A_S1, A_BETA, 6'd16, 1'b0, NEG, X1, 1'b0, A_QD1);
            6'd35: u = mac(1'b0, A_GX, A_Q0, 6'd17, 1'b0, POS, X1, 1'b0, A_QD1);
            6'd36: u = mac(1'b0, A_GZ, A_Q2, 6'd17, 1'b0, POS, X1, 1'b0, A_QD1);
            6'd37: u = mac(1'b0, A_GY, A_Q3, 6'd17, 1'b0, NEG, X1, 1'b1, A_QD1);
            6'd38: u = mac(1'b1, A_S2, A_BETA, 6'd16, 1'b0, NEG, X1, 1'b0, A_QD2);
            6'd39: u = mac(1'b0, A_GY, A_Q0, 6'd17, 1'b0, POS, X1, 1'b0, A_QD2);
            6'd40: u = mac(1'b0, A_GZ, A_Q1, 6'd17, 1'b0, NEG, X1, 1'b0, A_QD2);
            6'd41: u = mac(1'b0, A_GX, A_Q3, 6'd17, 1'b0, POS, X1, 1'b1, A_QD2);
            6'd42: u = mac(1'b1, A_S3, A_BETA, 6'd16, 1'b0, NEG, X1, 1'b0, A_QD3);
            6'd43: u = mac(1'b0, A_GZ, A_Q0, 6'd17, 1'b0, POS, X1, 1'b0, A_QD3);
            6'd44: u = mac(1'b0, A_GY, A_Q1, 6'd17, 1'b0, POS, X1, 1'b0, A_QD3);
            6'd45: u = mac(1'b0, A_GX, A_Q2, 6'd17, 1'b0, NEG, X1, 1'b1, A_QD3);
            6'd46: u = mac(1'b0, A_Q0, A_ONE, 6'd0, 1'b0, POS, X1, 1'b0, A_NQ0);
            6'd47: u = mac(1'b0, A_QD0, A_TS, 6'd32, 1'b1, POS, X1, 1'b0, A_NQ0);
            6'd48: u = mac(1'b0, A_QD0, A_TS, 6'd32, 1'b0, POS, X1, 1'b1, A_NQ0);
            6'd49: u = mac(1'b0, A_Q1, A_ONE, 6'd0, 1'b0, POS, X1, 1'b0, A_NQ1);
            6'd50: u = mac(1'b0, A_QD1, A_TS, 6'd32, 1'b1, POS, X1, 1'b0, A_NQ1);
            6'd51: u = mac(1'b0, A_QD1, A_TS, 6'd32, 1'b0, POS, X1, 1'b1, A_NQ1);
            6'd52: u = mac(1'b0, A_Q2, A_ONE, 6'd0, 1'b0, POS, X1, 1'b0, A_NQ2);
            6'd53: u = mac(1'b0, A_QD2, A_TS, 6'd32, 1'b1, POS, X1, 1'b0, A_NQ2);
            6'd54: u = mac(1'b0, A_QD2, A_TS, 6'd32, 1'b0, POS, X1, 1'b1, A_NQ2);
            6'd55: u = mac(1'b0, A_Q3, A_ONE, 6'd0, 1'b0, POS, X1, 1'b0, A_NQ3);
            6'd56: u = mac(1'b0, A_QD3, A_TS, 6'd32, 1'b1, POS, X1, 1'b0, A_NQ3);
            6'd57: u = mac(1'b0, A_QD3, A_TS, 6'd32, 1'b0, POS, X1, 1'b1, A_NQ3);
            6'd58: u = norm(1'b0, A_NQ0, A_Q0, 3'd4);
            default: u = fin();
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

FILE: design/imuof_ram.sv
// Generic scratch RAM with one write port and two registered read ports.
`default_nettype none
module imuof_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata0,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule
`default_nettype wire

FILE: design/imu_orientation_gradient_filter_core.sv
// Top level of the six-axis gradient-descent orientation filter with its sequencer.
//
// Each input word on the s_ channel carries one gyro and accelerometer sample.
// The block updates its attitude quaternion and returns one word on the m_
// channel: the new quaternion in m_tdata and the correction flag in m_tuser.
// The gain and the sample period are written through cfg_we, cfg_addr and
// cfg_wdata; the user must write them only while the block is idle, as the block
// itself does not enforce it. All arithmetic runs on one 32 by 32 bit multiplier
// and an accumulator, stepped by a small program, plus a bit-serial square root
// and divider that normalise vectors. The square root runs in 32 steps per vector
// and the divide in 31 steps per vector element. The block returns to idle after
// each sample, and s_tready is high only while the block is idle. The finished
// word is held in an output register, so the next sample is taken while it waits;
// should a later result be ready before the receiver takes it, the block holds
// there. Reset returns the attitude to the identity quaternion, the gain to 0.1
// and the period to one millisecond, and drops m_tvalid.
`default_nettype none
module imu_orientation_gradient_filter_core
    import imuof_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z from the lowest bit up.
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // quat_w, quat_x, quat_y, quat_z from the lowest bit up.
    output logic [127:0]      m_tdata,
    // correction_applied.
    output logic              m_tuser,
    input  wire logic         cfg_we,
    input  wire logic         cfg_addr,
    input  wire logic [31:0]  cfg_wdata
);

    state_t              state_reg, state_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [2:0]          e_reg, e_next;
    logic [15:0]         beta_reg, beta_next;
    logic [31:0]         ts_reg, ts_next;
    logic signed [31:0]  q_reg [4];
    logic signed [31:0]  q_next [4];
    logic                corr_reg, corr_next;
    logic                nzero_reg, nzero_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic signed [31:0]  gx_reg, gx_next, gy_reg, gy_next, gz_reg, gz_next;
    logic signed [16:0]  ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic signed [63:0]  acc_reg, acc_next;
    logic [63:0]         top_reg, top_next;
    logic [5:0]          rsh_reg, rsh_next, lsh_reg, lsh_next;
    logic [63:0]         sum_reg, sum_next;
    logic [63:0]         x_reg, x_next, res_reg, res_next, bit_reg, bit_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [32:0]         rem_reg, rem_next;
    logic [30:0]         quo_reg, quo_next;
    logic                sgn_reg, sgn_next;
    logic [31:0]         mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic                neg_reg, neg_next;
    logic [63:0]         prod_reg;
    logic [127:0]        out_q_reg, out_q_next;
    logic                out_c_reg, out_c_next;
    addr_t               raddr0_reg, raddr1_reg;

    uop_t                uop;
    addr_t               rd_addr0, rd_addr1;
    logic [63:0]         ram_rd0, ram_rd1;
    logic signed [63:0]  op_a, op_b;
    logic                wr_en;
    addr_t               wr_addr;
    logic [63:0]         wr_data;
    logic [63:0]         term, scaled, add_val;
    logic signed [63:0]  acc_sum;
    logic [63:0]         mag_a, mag_b, sq_sum;
    logic [31:0]         elem;
    logic [32:0]         trial;
    logic                ge;
    logic [30:0]         qclamp;
    logic                elem_last;
    logic signed [16:0]  az_neg;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic logic [31:0] elem_shift(input logic [63:0] m, input logic [5:0] rs,
                                               input logic [5:0] ls);
        logic [63:0] s;
        s = (m >> rs) << ls;
        return s[31:0];
    endfunction

    function automatic logic signed [63:0] reg_src(input addr_t a);
        logic signed [63:0] v;
        unique case (a)
            A_Q0:    v = 64'(q_reg[0]);
            A_Q1:    v = 64'(q_reg[1]);
            A_Q2:    v = 64'(q_reg[2]);
            A_Q3:    v = 64'(q_reg[3]);
            A_GX:    v = 64'(gx_reg);
            A_GY:    v = 64'(gy_reg);
            A_GZ:    v = 64'(gz_reg);
            A_AX:    v = 64'(ax_reg);
            A_AY:    v = 64'(ay_reg);
            A_AZ:    v = 64'(az_reg);
            A_BETA:  v = {48'd0, beta_reg};
            A_TS:    v = {32'd0, ts_reg};
            A_ONE:   v = 64'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign uop      = uop_rom(pc_reg);
    assign rd_addr0 = uop.a + {2'b00, e_reg};
    assign rd_addr1 = uop.b;

    imuof_ram #(
        .WIDTH (RF_WIDTH),
        .DEPTH (RF_DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .we     (wr_en & ~wr_addr[4]),
        .waddr  (wr_addr[RF_AW-1:0]),
        .wdata  (wr_data),
        .raddr0 (rd_addr0[RF_AW-1:0]),
        .raddr1 (rd_addr1[RF_AW-1:0]),
        .rdata0 (ram_rd0),
        .rdata1 (ram_rd1)
    );

    always_comb begin
        op_a = raddr0_reg[4] ? reg_src(raddr0_reg) : $signed(ram_rd0);
        op_b = raddr1_reg[4] ? reg_src(raddr1_reg) : $signed(ram_rd1);
    end

    assign mag_a     = mag64(op_a);
    assign mag_b     = mag64(op_b);
    assign elem      = elem_shift(mag_a, rsh_reg, lsh_reg);
    assign term      = uop.hi ? prod_reg : prod_reg >> uop.sh;
    assign scaled    = term << uop.clog;
    assign add_val   = (neg_reg ^ uop.cneg) ? 64'd0 - scaled : scaled;
    assign acc_sum   = acc_reg + $signed(add_val);
    assign sq_sum    = res_reg + bit_reg;
    assign trial     = (cnt_reg == 5'd0) ? rem_reg : {rem_reg[31:0], 1'b0};
    assign ge        = trial >= {1'b0, res_reg[31:0]};
    assign qclamp    = (quo_reg > 31'(ONE_Q30)) ? 31'(ONE_Q30) : quo_reg;
    assign elem_last = (e_reg + 3'd1) == uop.cnt;
    assign az_neg    = 17'sd0 - 17'(signed'(s_tdata[143:128]));

    always_comb begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        e_next        = e_reg;
        beta_next     = beta_reg;
        ts_next       = ts_reg;
        q_next        = q_reg;
        corr_next     = corr_reg;
        nzero_next    = nzero_reg;
        m_tvalid_next = m_tvalid_reg;
        gx_next       = gx_reg;
        gy_next       = gy_reg;
        gz_next       = gz_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        az_next       = az_reg;
        acc_next      = acc_reg;
        top_next      = top_reg;
        rsh_next      = rsh_reg;
        lsh_next      = lsh_reg;
        sum_next      = sum_reg;
        x_next        = x_reg;
        res_next      = res_reg;
        bit_next      = bit_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        sgn_next      = sgn_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        neg_next      = neg_reg;
        out_q_next    = out_q_reg;
        out_c_next    = out_c_reg;
        wr_en         = 1'b0;
        wr_addr       = uop.d + {2'b00, e_reg};
        wr_data       = acc_sum;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_BETA: beta_next = cfg_wdata[15:0];
                CFG_STEP: ts_next   = cfg_wdata;
                default:  ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    gx_next    = s_tdata[31:0];
                    gy_next    = s_tdata[63:32];
                    gz_next    = s_tdata[95:64];
                    ax_next    = 17'(signed'(s_tdata[111:96]));
                    ay_next    = 17'(signed'(s_tdata[127:112]));
                    az_next    = az_neg;
                    corr_next  = (|s_tdata[143:96]);
                    acc_next   = '0;
                    pc_next    = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (uop.cond && !corr_reg) begin
                    pc_next = pc_reg + 1'b1;
                end else begin
                    unique case (uop.op)
                        OP_MAC: state_next = ST_OPER;
                        OP_NORM: begin
                            top_next   = '0;
                            rsh_next   = '0;
                            lsh_next   = '0;
                            state_next = ST_NS_RD;
                        end
                        OP_OUT:  state_next = ST_OUT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OPER: begin
                mul_a_next = uop.hi ? mag_a[63:32] : mag_a[31:0];
                mul_b_next = mag_b[31:0];
                neg_next   = op_a[63] ^ op_b[63];
                state_next = ST_MULT;
            end
            ST_MULT: begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (uop.st) begin
                    wr_en    = 1'b1;
                    acc_next = '0;
                end else begin
                    acc_next = acc_sum;
                end
                pc_next    = pc_reg + 1'b1;
                state_next = ST_FETCH;
            end
            ST_NS_RD: begin
                state_next = ST_NS_CHK;
            end
            ST_NS_CHK: begin
                if (mag_a > top_reg) begin
                    top_next = mag_a;
                end
                if (elem_last) begin
                    e_next     = '0;
                    state_next = ST_N_SHIFT;
                end else begin
                    e_next     = e_reg + 3'd1;
                    state_next = ST_NS_RD;
                end
            end
            ST_N_SHIFT: begin
                if (top_reg == 64'd0) begin
                    nzero_next = 1'b1;
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_FETCH;
                end else if (|top_reg[63:30]) begin
                    top_next = top_reg >> 1;
                    rsh_next = rsh_reg + 6'd1;
                end else if (!top_reg[29]) begin
                    top_next = top_reg << 1;
                    lsh_next = lsh_reg + 6'd1;
                end else begin
                    nzero_next = 1'b0;
                    sum_next   = '0;
                    state_next = ST_NQ_RD;
                end
            end
            ST_NQ_RD: begin
                state_next = ST_NQ_OP;
            end
            ST_NQ_OP: begin
                mul_a_next = elem;
                mul_b_next = elem;
                state_next = ST_NQ_MUL;
            end
            ST_NQ_MUL: begin
                state_next = ST_NQ_ACC;
            end
            ST_NQ_ACC: begin
                sum_next = sum_reg + prod_reg;
                if (elem_last) begin
                    e_next     = '0;
                    x_next     = sum_reg + prod_reg;
                    res_next   = '0;
                    bit_next   = 64'h4000_0000_0000_0000;
                    cnt_next   = '0;
                    state_next = ST_N_SQRT;
                end else begin
                    e_next     = e_reg + 3'd1;
                    state_next = ST_NQ_RD;
                end
            end
            ST_N_SQRT: begin
                if (x_reg >= sq_sum) begin
                    x_next   = x_reg - sq_sum;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = ST_ND_RD;
                end
            end
            ST_ND_RD: begin
                state_next = ST_ND_OP;
            end
            ST_ND_OP: begin
                rem_next   = {1'b0, elem};
                quo_next   = '0;
                sgn_next   = op_a[63];
                cnt_next   = '0;
                state_next = ST_N_DIV;
            end
            ST_N_DIV: begin
                rem_next = ge ? trial - {1'b0, res_reg[31:0]} : trial;
                quo_next = {quo_reg[29:0], ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd30) begin
                    state_next = ST_N_WR;
                end
            end
            ST_N_WR: begin
                wr_en   = 1'b1;
                wr_data = sgn_reg ? 64'd0 - {33'd0, qclamp} : {33'd0, qclamp};
                if (elem_last) begin
                    e_next     = '0;
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_FETCH;
                end else begin
                    e_next     = e_reg + 3'd1;
                    state_next = ST_ND_RD;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    if (nzero_reg) begin
                        q_next[0]  = ONE_Q30;
                        q_next[1]  = '0;
                        q_next[2]  = '0;
                        q_next[3]  = '0;
                        out_q_next = {96'd0, ONE_Q30};
                    end else begin
                        out_q_next = {q_reg[3], q_reg[2], q_reg[1], q_reg[0]};
                    end
                    out_c_next    = corr_reg;
                    m_tvalid_next = 1'b1;
                    pc_next       = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (wr_en && wr_addr[4]) begin
            q_next[wr_addr[1:0]] = wr_data[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pc_reg       <= '0;
            e_reg        <= '0;
            beta_reg     <= 16'd6554;
            ts_reg       <= 32'd4294967;
            q_reg[0]     <= ONE_Q30;
            q_reg[1]     <= '0;
            q_reg[2]     <= '0;
            q_reg[3]     <= '0;
            corr_reg     <= 1'b0;
            nzero_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            e_reg        <= e_next;
            beta_reg     <= beta_next;
            ts_reg       <= ts_next;
            q_reg        <= q_next;
            corr_reg     <= corr_next;
            nzero_reg    <= nzero_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gx_reg     <= gx_next;
        gy_reg     <= gy_next;
        gz_reg     <= gz_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        az_reg     <= az_next;
        acc_reg    <= acc_next;
        top_reg    <= top_next;
        rsh_reg    <= rsh_next;
        lsh_reg    <= lsh_next;
        sum_reg    <= sum_next;
        x_reg      <= x_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        sgn_reg    <= sgn_next;
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        neg_reg    <= neg_next;
        prod_reg   <= mul_a_reg * mul_b_reg;
        out_q_reg  <= out_q_next;
        out_c_reg  <= out_c_next;
        raddr0_reg <= rd_addr0;
        raddr1_reg <= rd_addr1;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_q_reg;
    assign m_tuser  = out_c_reg;

endmodule
`default_nettype wire
